// ----- rtl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// Stuffed CRC frame encoder package
// Shared types, register codes and the reflected CRC-CCITT byte update.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CRC_W-1:0] crc_t;

    localparam crc_t CRC_INIT = 16'hFFFF;
    localparam crc_t CRC_POLY = 16'h8408;

    localparam byte_t SYNC_RESET = 8'd126;
    localparam byte_t ESCAPE_RESET = 8'd125;
    localparam byte_t MASK_RESET = 8'd32;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_SYNC   = 2'd0,
        REG_ESCAPE = 2'd1,
        REG_MASK   = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        byte_t sync_byte;
        byte_t escape_byte;
        byte_t escape_mask;
    } cfg_t;

    // Everything the line side needs to send the beats of one message byte.
    typedef struct packed {
        logic  need_sync;
        byte_t data;
        logic  last;
        byte_t crc_hi;
        byte_t crc_lo;
    } run_t;

    // Which symbol of the run the line side is sending.
    typedef enum logic [1:0] {
        PH_SYNC   = 2'd0,
        PH_DATA   = 2'd1,
        PH_CRC_HI = 2'd2,
        PH_CRC_LO = 2'd3
    } phase_t;

    function automatic crc_t crc_byte(input crc_t crc, input byte_t b);
        crc_t c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/sce_intf.sv -----
// ----------------------------------------------------------------------------
// Stuffed CRC frame encoder channels
// Valid/ready channels for message bytes in and line bytes out.
// ----------------------------------------------------------------------------
interface sce_in_if;
    logic          valid;
    logic          ready;
    sce_pkg::byte_t data_byte;
    logic          last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sce_out_if;
    logic          valid;
    logic          ready;
    sce_pkg::byte_t line_byte;
    logic          run_last;
    logic          frame_end;

    modport source (output valid, output line_byte, output run_last, output frame_end,
                    input ready);
    modport sink (input valid, input line_byte, input run_last, input frame_end,
                  output ready);
endinterface

// ----- rtl/stuffed_crc_frame_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Stuffed CRC frame encoder core
// Frames message bytes with a sync byte, byte stuffing and a CRC-16 tail.
// ----------------------------------------------------------------------------
// Output timing: the first line beat of a message byte is registered and offered
//   in the cycle after the edge that accepts the byte.
// Throughput: one line beat per cycle while the receiver is ready; a message
//   byte yields 1 to 7 beats, and the next message byte is accepted on the edge
//   that takes its last beat.
// Reset: asynchronous, active low; registers return to their defaults, the
//   CRC to all ones, and the encoder waits for the first byte of a frame.
module stuffed_crc_frame_encoder_core (
    input  logic                               clk,
    input  logic                               rst_n,
    sce_in_if.sink                             in_ch,
    sce_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sce_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import sce_pkg::*;

    cfg_t cfg;
    run_t run;
    logic in_fire;
    logic in_frame;
    logic in_ready;

    // Register file. Software must write it only while the encoder is idle; the
    // block does not enforce it. The emitter decodes stuffing from the live values.
    sce_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ch.ready = in_ready;
    assign in_fire = in_ch.valid && in_ready;

    // Input side: the CRC update for the accepted byte is computed here and
    // captured, together with the byte, into the emitter's run register.
    sce_frame_state u_frame_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (in_ch.data_byte),
        .last_byte (in_ch.last_byte),
        .run       (run),
        .in_frame  (in_frame)
    );

    // Output side: walks the run one line beat per cycle while the receiver is
    // ready. The run register parts the two sides, so a finished beat may wait
    // while a new message byte is taken in the cycle its last beat leaves.
    sce_line_emitter u_line_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .run_in   (run),
        .out_ch   (out_ch)
    );

    // The end of a frame is always the last beat of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_end |-> out_ch.run_last)
    else $error("frame_end without run_last");

    // An idle emitter must take a new message byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
    else $error("emitter idle but input not ready");

    // Accepting the last message byte closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.last_byte |=> !in_frame)
    else $error("frame still open after last byte");

    // A byte that is not the last of its frame leaves a frame open.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_ch.last_byte |=> in_frame)
    else $error("frame not opened");

endmodule

// ----- rtl/sce_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file for sync byte, escape byte and escape mask.
// ----------------------------------------------------------------------------
module sce_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sce_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sce_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sce_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output sce_pkg::cfg_t                      cfg
);
    import sce_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SYNC:   cfg_next.sync_byte = pwdata[BYTE_W-1:0];
                REG_ESCAPE: cfg_next.escape_byte = pwdata[BYTE_W-1:0];
                REG_MASK:   cfg_next.escape_mask = pwdata[BYTE_W-1:0];
                REG_NONE:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SYNC:   prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, cfg_reg.sync_byte};
            REG_ESCAPE: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, cfg_reg.escape_byte};
            REG_MASK:   prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, cfg_reg.escape_mask};
            REG_NONE:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_byte <= SYNC_RESET;
            cfg_reg.escape_byte <= ESCAPE_RESET;
            cfg_reg.escape_mask <= MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/sce_frame_state.sv -----
// ----------------------------------------------------------------------------
// Frame state and CRC
// Tracks frame membership and the running CRC, and builds the run of one byte.
// ----------------------------------------------------------------------------
module sce_frame_state (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  sce_pkg::byte_t  data_byte,
    input  logic            last_byte,
    output sce_pkg::run_t   run,
    output logic            in_frame
);
    import sce_pkg::*;

    crc_t crc_reg;
    crc_t crc_next;
    crc_t crc_upd;
    logic in_frame_reg;
    logic in_frame_next;

    assign crc_upd = crc_byte(crc_reg, data_byte);

    always_comb
    begin
        run.need_sync = !in_frame_reg;
        run.data = data_byte;
        run.last = last_byte;
        run.crc_hi = crc_upd[CRC_W-1:BYTE_W];
        run.crc_lo = crc_upd[BYTE_W-1:0];
    end

    always_comb
    begin
        crc_next = crc_reg;
        in_frame_next = in_frame_reg;
        if (in_fire)
        begin
            // The tail closes the frame and the CRC starts over.
            crc_next = last_byte ? CRC_INIT : crc_upd;
            in_frame_next = !last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

    assign in_frame = in_frame_reg;

endmodule

// ----- rtl/sce_line_emitter.sv -----
// ----------------------------------------------------------------------------
// Line emitter
// Holds one run and sends its sync, stuffed data and stuffed CRC bytes.
// ----------------------------------------------------------------------------
module sce_line_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  sce_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  sce_pkg::run_t   run_in,
    sce_out_if.source       out_ch
);
    import sce_pkg::*;

    phase_t state_reg;
    phase_t state_next;
    logic   esc_reg;
    logic   esc_next;
    logic   busy_reg;
    logic   busy_next;
    run_t   run_reg;

    byte_t  sym;
    logic   stuff;
    logic   seg_done;
    logic   last_sym;
    logic   fin;
    logic   out_fire;
    logic   load;

    // Output decode from the held run.
    always_comb
    begin
        unique case (state_reg)
            PH_SYNC:
            begin
                sym = cfg.sync_byte;
                last_sym = 1'b0;
            end
            PH_DATA:
            begin
                sym = run_reg.data;
                last_sym = !run_reg.last;
            end
            PH_CRC_HI:
            begin
                sym = run_reg.crc_hi;
                last_sym = 1'b0;
            end
            PH_CRC_LO:
            begin
                sym = run_reg.crc_lo;
                last_sym = 1'b1;
            end
        endcase
        stuff = (state_reg != PH_SYNC) &&
                ((sym == cfg.sync_byte) || (sym == cfg.escape_byte));
        seg_done = !stuff || esc_reg;
        fin = seg_done && last_sym;

        out_ch.valid = busy_reg;
        out_ch.line_byte = esc_reg ? (sym ^ cfg.escape_mask) :
                           (stuff ? cfg.escape_byte : sym);
        out_ch.run_last = fin;
        out_ch.frame_end = fin && (state_reg == PH_CRC_LO);
    end

    assign out_fire = busy_reg && out_ch.ready;
    assign in_ready = !busy_reg || (out_ch.ready && fin);
    assign load = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        esc_next = esc_reg;
        if (out_fire && !fin)
        begin
            if (!seg_done)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                unique case (state_reg)
                    PH_SYNC:   state_next = PH_DATA;
                    PH_DATA:   state_next = PH_CRC_HI;
                    PH_CRC_HI: state_next = PH_CRC_LO;
                    PH_CRC_LO: state_next = PH_CRC_LO;
                endcase
            end
        end
        if (load)
        begin
            state_next = run_in.need_sync ? PH_SYNC : PH_DATA;
            esc_next = 1'b0;
        end
        busy_next = load ? 1'b1 : ((out_fire && fin) ? 1'b0 : busy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_SYNC;
            esc_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg <= esc_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run_in;
        end
    end

endmodule

// ----- verif/tb_stuffed_crc_frame_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stuffed CRC frame encoder core testbench
// Sends message bytes into the encoder and checks every line beat it returns
// against a local model of the framing, stuffing and CRC-16 tail. The model
// state covers the running CRC, whether a frame is open and the three
// registers. A directed table comes first, then random frames under three
// idling settings with register changes in between. Registers are written and
// read back over the APB port.
// ----------------------------------------------------------------------------
module tb_stuffed_crc_frame_encoder_core;

    import sce_pkg::*;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 8;
    // Cycles with no beat moving on either channel before the run gives up.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    // Quiet cycles that let the encoder settle before a register write or
    // before the final verdict.
    localparam int SETTLE_CYCLES = 3;
    localparam int TAIL_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 78;

    // One beat on the line side, as the encoder should present it.
    typedef struct packed {
        byte_t line_byte;
        logic  run_last;
        logic  frame_end;
    } line_beat_t;

    // A row of the directed table: either a message byte or a register write.
    typedef enum logic {
        ROW_BYTE = 1'b0,
        ROW_REG  = 1'b1
    } row_kind_t;

    // For byte rows, n_typed > 0 means the line beats are written out in
    // typed (first beat in the top byte) rather than taken from the model.
    typedef struct {
        row_kind_t   kind;
        reg_idx_t    idx;
        byte_t       data;
        logic        last;
        int          n_typed;
        logic [23:0] typed;
    } stim_row_t;

    localparam int N_DIR = 30;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    sce_in_if msg_ch ();
    sce_out_if line_ch ();

    stuffed_crc_frame_encoder_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (msg_ch),
        .out_ch  (line_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model state: the registers as last written, the running CRC and
    // whether the next message byte continues an open frame.
    byte_t sync_now;
    byte_t escape_now;
    byte_t mask_now;
    crc_t  crc_run;
    logic  frame_open;

    // Line beats the model has worked out and the encoder still owes us.
    line_beat_t line_beats_due[$];
    // Beats of the message byte being accepted right now.
    line_beat_t staged_beats[$];

    int err_count = 0;
    int stall_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    // Directed table. The first rows run straight after reset, so the sync
    // byte and the plain or escaped data byte can be typed in. Rows that end
    // a frame carry a CRC tail and are left to the model.
    stim_row_t dir_table [N_DIR] = '{
        // First byte after reset: raw sync, then the byte itself.
        '{ROW_BYTE, REG_NONE,   8'h00, 1'b0, 2, 24'h7E0000},
        // A byte equal to the sync byte is escaped.
        '{ROW_BYTE, REG_NONE,   8'h7E, 1'b0, 2, 24'h7D5E00},
        // A byte equal to the escape byte is escaped as well.
        '{ROW_BYTE, REG_NONE,   8'h7D, 1'b0, 2, 24'h7D5D00},
        '{ROW_BYTE, REG_NONE,   8'hFF, 1'b0, 1, 24'hFF0000},
        '{ROW_BYTE, REG_NONE,   8'h55, 1'b1, 0, 24'h000000},
        // Single-byte frames, including one whose only byte needs escaping.
        '{ROW_BYTE, REG_NONE,   8'h7E, 1'b1, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h00, 1'b1, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'hFF, 1'b1, 0, 24'h000000},
        // Open a frame, then change the sync byte in the middle of it.
        '{ROW_BYTE, REG_NONE,   8'h12, 1'b0, 2, 24'h7E1200},
        '{ROW_REG,  REG_SYNC,   8'h12, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h12, 1'b0, 2, 24'h7D3200},
        '{ROW_BYTE, REG_NONE,   8'h7E, 1'b1, 0, 24'h000000},
        // Sync equal to escape: the frame opens with the shared value raw.
        '{ROW_REG,  REG_SYNC,   8'h7D, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h7D, 1'b0, 3, 24'h7D7D5D},
        '{ROW_BYTE, REG_NONE,   8'h7E, 1'b1, 0, 24'h000000},
        // A write to the unused address must change nothing.
        '{ROW_REG,  REG_NONE,   8'hAA, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'hAA, 1'b0, 2, 24'h7DAA00},
        '{ROW_BYTE, REG_NONE,   8'h01, 1'b1, 0, 24'h000000},
        // Register extremes: sync 0x00, escape 0xFF, mask 0x00 and 0xFF.
        '{ROW_REG,  REG_SYNC,   8'h00, 1'b0, 0, 24'h000000},
        '{ROW_REG,  REG_ESCAPE, 8'hFF, 1'b0, 0, 24'h000000},
        '{ROW_REG,  REG_MASK,   8'h00, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h00, 1'b0, 3, 24'h00FF00},
        '{ROW_BYTE, REG_NONE,   8'hFF, 1'b0, 2, 24'hFFFF00},
        '{ROW_REG,  REG_MASK,   8'hFF, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'hFF, 1'b1, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h80, 1'b1, 0, 24'h000000},
        // Back to the reset values before the random part.
        '{ROW_REG,  REG_SYNC,   8'h7E, 1'b0, 0, 24'h000000},
        '{ROW_REG,  REG_ESCAPE, 8'h7D, 1'b0, 0, 24'h000000},
        '{ROW_REG,  REG_MASK,   8'h20, 1'b0, 0, 24'h000000},
        '{ROW_BYTE, REG_NONE,   8'h3C, 1'b1, 0, 24'h000000}
    };

    // Clock with a 4 ns period.
    initial clk = 1'b0;
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the encoder
    // ------------------------------------------------------------------

    // Reflected CRC-CCITT, one input bit at a time, LSB first.
    function automatic crc_t crc_advance(input crc_t c, input byte_t d);
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0] ^ d[i])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void stage_beat(input byte_t b);
        line_beat_t beat;
        beat.line_byte = b;
        beat.run_last = 1'b0;
        beat.frame_end = 1'b0;
        staged_beats.push_back(beat);
    endfunction

    // Sync and escape values inside the frame go out as escape plus the
    // byte XORed with the mask; everything else goes out as is.
    function automatic void stage_stuffed(input byte_t b);
        if (b == sync_now || b == escape_now)
        begin
            stage_beat(escape_now);
            stage_beat(b ^ mask_now);
        end
        else
        begin
            stage_beat(b);
        end
    endfunction

    // Works out the line beats of one accepted message byte and advances
    // the model state.
    function automatic void encode_message_byte(input byte_t d, input logic l);
        line_beat_t tail;
        staged_beats.delete();
        if (!frame_open)
        begin
            stage_beat(sync_now);
            frame_open = 1'b1;
        end
        stage_stuffed(d);
        crc_run = crc_advance(crc_run, d);
        if (l)
        begin
            stage_stuffed(crc_run[15:8]);
            stage_stuffed(crc_run[7:0]);
            crc_run = CRC_INIT;
            frame_open = 1'b0;
        end
        // The final beat of the run carries run_last, and frame_end too
        // when the run closes the frame.
        tail = staged_beats.pop_back();
        tail.run_last = 1'b1;
        tail.frame_end = l;
        staged_beats.push_back(tail);
    endfunction

    function automatic void model_reg_write(input reg_idx_t idx, input byte_t v);
        case (idx)
            REG_SYNC:   sync_now = v;
            REG_ESCAPE: escape_now = v;
            REG_MASK:   mask_now = v;
            default:    ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want,
                 $realtime);
        err_count++;
    endtask

    // Every line beat taken by the receiver is matched against the oldest
    // beat the model still owes.
    always @(posedge clk)
    begin : line_monitor
        line_beat_t want;
        if (rst_n && line_ch.valid && line_ch.ready)
        begin
            if (line_beats_due.size() == 0)
            begin
                report_mismatch("line beat with none due", line_ch.line_byte, 0);
            end
            else
            begin
                want = line_beats_due.pop_front();
                if (line_ch.line_byte !== want.line_byte)
                    report_mismatch("line_byte", line_ch.line_byte, want.line_byte);
                if (line_ch.run_last !== want.run_last)
                    report_mismatch("run_last", line_ch.run_last, want.run_last);
                if (line_ch.frame_end !== want.frame_end)
                    report_mismatch("frame_end", line_ch.frame_end, want.frame_end);
            end
        end
    end

    // Watchdog: a hung handshake ends the run instead of hanging it.
    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (line_ch.valid && line_ch.ready))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Ready changes only at the falling edge. It drops at random by the
    // current idle percentage, and stays low for the whole hold-off.
    always @(negedge clk)
    begin
        line_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off, counted here so that the sender keeps offering
    // bytes meanwhile and the encoder has to push back on its input. The flag
    // moves at the rising edge so that the receiver process reads it cleanly.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender side and configuration. Every task here starts and ends just
    // after a falling edge.
    // ------------------------------------------------------------------

    // Offers one message byte, after a random number of idle cycles, and
    // holds it until the encoder takes the beat. The model runs on the edge
    // of acceptance; typed rows replace the modelled beats with their own.
    task automatic push_msg_byte(input byte_t d, input logic l, input int n_typed,
                                 input logic [23:0] typed);
        line_beat_t beat;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.data_byte <= d;
        msg_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        encode_message_byte(d, l);
        if (n_typed == 0)
        begin
            foreach (staged_beats[k])
                line_beats_due.push_back(staged_beats[k]);
        end
        else
        begin
            for (int k = 0; k < n_typed; k++)
            begin
                beat.line_byte = typed[23 - 8*k -: 8];
                beat.run_last = (k == n_typed - 1);
                beat.frame_end = 1'b0;
                line_beats_due.push_back(beat);
            end
        end
        @(negedge clk);
    endtask

    // Stops offering and waits until every owed line beat has come out,
    // then lets the encoder settle.
    task automatic drain_line();
        msg_ch.valid <= 1'b0;
        while (line_beats_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write: setup phase, access phase, then idle. The upper
    // data bits are random since only the low byte of a register is kept.
    task automatic reg_write(input reg_idx_t idx, input byte_t v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_reg_write(idx, v);
        @(negedge clk);
    endtask

    // APB read; the data is taken at the rising edge that ends the access.
    task automatic reg_read(input reg_idx_t idx, input byte_t want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[BYTE_W-1:0] !== want)
            report_mismatch("register read", prdata[BYTE_W-1:0], want);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_regs();
        reg_read(REG_SYNC, sync_now);
        reg_read(REG_ESCAPE, escape_now);
        reg_read(REG_MASK, mask_now);
    endtask

    // Register values lean toward the two extremes.
    function automatic byte_t random_reg_value();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return byte_t'($urandom_range(255));
        endcase
    endfunction

    // Rewrites all three registers; sometimes the sync and escape bytes
    // end up equal.
    task automatic reconfigure();
        reg_write(REG_SYNC, random_reg_value());
        reg_write(REG_ESCAPE, random_reg_value());
        reg_write(REG_MASK, random_reg_value());
        if ($urandom_range(3) == 0)
            reg_write(REG_SYNC, escape_now);
        check_regs();
    endtask

    // Message bytes hit the sync and escape values often enough to keep the
    // stuffing path busy.
    function automatic byte_t random_data();
        case ($urandom_range(9))
            0:       return sync_now;
            1:       return escape_now;
            2:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            default: return byte_t'($urandom_range(255));
        endcase
    endfunction

    // Random frames, mostly short with an occasional long one. Now and then
    // the sender pauses until the line side is empty, and now and then a
    // register changes in the middle of a frame.
    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                drain_line();
            if ($urandom_range(7) == 0)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(39) == 0)
                begin
                    drain_line();
                    reg_write(reg_idx_t'($urandom_range(3)), random_reg_value());
                    check_regs();
                end
                push_msg_byte(random_data(), k == len - 1, 0, 24'h000000);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Every input is known from time zero.
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        msg_ch.valid = 1'b0;
        msg_ch.data_byte = '0;
        msg_ch.last_byte = 1'b0;
        line_ch.ready = 1'b0;

        sync_now = SYNC_RESET;
        escape_now = ESCAPE_RESET;
        mask_now = MASK_RESET;
        crc_run = CRC_INIT;
        frame_open = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The registers must read back their reset values.
        check_regs();

        // Directed table, sender idle 16 percent, receiver idle 67 percent.
        tx_idle_pct = 16;
        rx_idle_pct = 67;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_REG)
            begin
                drain_line();
                reg_write(dir_table[i].idx, dir_table[i].data);
                check_regs();
            end
            else
            begin
                push_msg_byte(dir_table[i].data, dir_table[i].last, dir_table[i].n_typed,
                              dir_table[i].typed);
            end
        end

        // Random frames under the same idling.
        run_random_phase(ITEMS_PER_PHASE);

        // Swap the idling: a slow sender and a mostly ready receiver.
        drain_line();
        reconfigure();
        tx_idle_pct = 67;
        rx_idle_pct = 16;
        run_random_phase(ITEMS_PER_PHASE);

        // No idling on either side. The receiver hold-off starts here, so
        // the encoder backs up against its input.
        drain_line();
        reconfigure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go = 1'b1;
        run_random_phase(ITEMS_PER_PHASE);

        // Wait for the last owed beats, then give any stray beat time to
        // show up before the verdict.
        drain_line();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- stuffed_crc_frame_encoder_core.f -----
rtl/sce_pkg.sv
rtl/sce_intf.sv
rtl/sce_cfg_regs.sv
rtl/sce_frame_state.sv
rtl/sce_line_emitter.sv
rtl/stuffed_crc_frame_encoder_core.sv
verif/tb_stuffed_crc_frame_encoder_core.sv
